/* sv/bhash_pkg.sv */
// shared types, constants and mixing functions for the blocked lane word hash
// no dependencies; imported by the multiplier unit and the top level
package bhash_pkg;

   // multiplier constants of the twist and of the lane update
   localparam logic [31:0] TWIST_W_MULT = 32'h9908_b0df;
   localparam logic [31:0] TWIST_H_MULT = 32'd1812433253;
   localparam logic [31:0] LANE_MULT    = 32'd65521;

   // shift amounts of the twist
   localparam int unsigned W_SHIFT_A = 15;
   localparam int unsigned W_SHIFT_B = 17;
   localparam int unsigned H_SHIFT   = 62;

   // command to the shared multiply-add unit: result = x * coef + addend
   typedef struct packed {
      logic [63:0] x;
      logic [31:0] coef;
      logic [63:0] addend;
   } mul_cmd_type;

   // xor-shift and add-shift applied to the scaled word
   function automatic logic [63:0] twist_mix_word(input logic [63:0] w1);
      logic signed [63:0] s1;
      logic signed [63:0] s2;
      logic [63:0]        w2;
      s1 = w1;
      w2 = w1 ^ 64'(s1 >>> W_SHIFT_A);
      s2 = w2;
      return w2 + 64'(s2 >>> W_SHIFT_B);
   endfunction

   // xor-shift applied to the running hash
   function automatic logic [63:0] twist_mix_hash(input logic [63:0] h);
      logic signed [63:0] s;
      s = h;
      return h ^ 64'(s >>> H_SHIFT);
   endfunction

endpackage

/* sv/bhash_ram.sv */
// generic single write port, single read port memory with registered read
// no dependencies; holds the hash lanes
module bhash_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/bhash_mul.sv */
// shared 64x32 multiply-add unit built on one 32x32 multiplier, two passes
// depends on bhash_pkg for the command type
module bhash_mul
   import bhash_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  mul_cmd_type cmd,
   output logic        done,
   output logic [63:0] result
);

   typedef enum logic [1:0] {
      M_IDLE,
      M_LO,
      M_HI
   } mul_state_type;

   mul_state_type state_ff;
   logic [63:0]   x_ff;
   logic [31:0]   coef_ff;
   logic [63:0]   acc_ff;
   logic          done_ff;
   logic [31:0]   mul_a;
   logic [63:0]   prod;

   // one 32x32 multiplier, low half first, then high half
   always_comb begin
      mul_a = (state_ff == M_HI) ? x_ff[63:32] : x_ff[31:0];
      prod  = 64'(mul_a) * 64'(coef_ff);
   end

   // sequencer and accumulation of the partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         // done is registered, high in the cycle after the high pass
         done_ff <= (state_ff == M_HI);
         case (state_ff)
            M_IDLE: begin
               if (start) begin
                  x_ff     <= cmd.x;
                  coef_ff  <= cmd.coef;
                  acc_ff   <= cmd.addend;
                  state_ff <= M_LO;
               end
            end
            M_LO: begin
               acc_ff   <= acc_ff + prod;
               state_ff <= M_HI;
            end
            M_HI: begin
               acc_ff   <= acc_ff + {prod[31:0], 32'h0};
               state_ff <= M_IDLE;
            end
            default: begin
               state_ff <= M_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

/* sv/blocked_lane_word_hash64.sv */
// Blocked lane word hash, 64 bits: top level with the item sequencer.
// Each request transaction carries one 64-bit message word (or none, when
// req_no_data is set); req_is_last closes the message and req_byte_length
// goes into the final twist. One response transaction carries the hash.
// csr_hash_seed is written with csr_wr_en and is taken at message start.
// req_ready is high only while no transaction is in work. All work is
// paced by the one shared 32x32 multiplier (two passes per 64-bit product):
//   twist: scaled word product, then hash term; first transaction of a
//   message: a twist per lane first loads the lanes from the seed
//   word without group end: lane read, lane update product, lane write
//   group fold, after the word that fills the group: read and twist each lane
//   last transaction: fold of a partial group, final twist, output load
// After reset no message is open, the seed is zero and the lane memory
// needs no clearing. A finished hash waits in the output register; while
// it is not taken the block still accepts transactions, and only a further
// hash stalls until the output register frees.
module blocked_lane_word_hash64
   import bhash_pkg::*;
#(
   parameter int LANE_COUNT = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic signed [63:0] csr_hash_seed,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [63:0]        req_data_word,
   input  logic               req_is_last,
   input  logic               req_no_data,
   input  logic [30:0]        req_byte_length,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_hash_value
);

   localparam int IDX_W = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LANE_COUNT - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DATA,
      S_UPD_RD,
      S_UPD_WAIT,
      S_TAIL,
      S_FOLD_GO,
      S_FOLD_RD,
      S_TW_W,
      S_TW_WAIT1,
      S_TW_WAIT2,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      MODE_INIT,
      MODE_FOLD,
      MODE_FINAL
   } mode_type;

   state_type   state_ff;
   mode_type    mode_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] pos_ff;
   logic        in_msg_ff;
   logic [63:0] seed_ff;
   logic [63:0] acc_ff;
   logic [63:0] tw_h_ff;
   logic [63:0] tw_w_ff;
   logic [63:0] word_ff;
   logic        last_ff;
   logic        no_data_ff;
   logic [30:0] len_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_hash_ff;

   logic [IDX_W-1:0] idx_in;
   logic [IDX_W-1:0] pos_in;
   logic        mul_start;
   mul_cmd_type mul_cmd;
   logic        mul_done;
   logic [63:0] mul_result;
   logic        ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [63:0] ram_rd_data;

   assign idx_in = IDX_W'(idx_ff + 1'b1);
   assign pos_in = IDX_W'(pos_ff + 1'b1);

   // shared multiply-add unit
   bhash_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .cmd    (mul_cmd),
      .done   (mul_done),
      .result (mul_result)
   );

   // lane memory
   bhash_ram #(
      .WIDTH (64),
      .DEPTH (LANE_COUNT)
   ) u_lanes (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (mul_result),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // multiplier commands: scaled word, hash term plus mixed word, lane update
   always_comb begin
      mul_start      = 1'b0;
      mul_cmd.x      = tw_w_ff;
      mul_cmd.coef   = TWIST_W_MULT;
      mul_cmd.addend = 64'h0;
      case (state_ff)
         S_TW_W: begin
            mul_start = 1'b1;
         end
         S_TW_WAIT1: begin
            mul_start      = mul_done;
            mul_cmd.x      = twist_mix_hash(tw_h_ff);
            mul_cmd.coef   = TWIST_H_MULT;
            mul_cmd.addend = twist_mix_word(mul_result);
         end
         S_UPD_RD: begin
            mul_start      = 1'b1;
            mul_cmd.x      = ram_rd_data;
            mul_cmd.coef   = LANE_MULT;
            mul_cmd.addend = word_ff;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   // lane memory addressing: lane writes and read ahead
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_rd_addr = '0;
      case (state_ff)
         S_DATA: begin
            ram_rd_addr = pos_ff;
         end
         S_UPD_WAIT: begin
            ram_wr_en   = mul_done;
            ram_wr_addr = pos_ff;
         end
         S_TW_WAIT2: begin
            ram_wr_en   = mul_done && (mode_ff == MODE_INIT);
            ram_rd_addr = idx_in;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   // item sequencer, message state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_INIT;
         idx_ff       <= '0;
         pos_ff       <= '0;
         in_msg_ff    <= 1'b0;
         seed_ff      <= 64'h0;
         acc_ff       <= 64'h0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            seed_ff <= csr_hash_seed;
         end
         // output register empties when taken, unless a new hash loads now
         if (rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  word_ff    <= req_data_word;
                  last_ff    <= req_is_last;
                  no_data_ff <= req_no_data;
                  len_ff     <= req_byte_length;
                  if (in_msg_ff) begin
                     state_ff <= S_DATA;
                  end else begin
                     // load the lane chain from the seed
                     mode_ff  <= MODE_INIT;
                     idx_ff   <= '0;
                     tw_h_ff  <= seed_ff;
                     tw_w_ff  <= 64'h0;
                     state_ff <= S_TW_W;
                  end
               end
            end
            S_DATA: begin
               state_ff <= no_data_ff ? S_TAIL : S_UPD_RD;
            end
            S_UPD_RD: begin
               state_ff <= S_UPD_WAIT;
            end
            S_UPD_WAIT: begin
               if (mul_done) begin
                  if (pos_ff == LAST_IDX) begin
                     pos_ff   <= '0;
                     state_ff <= S_FOLD_GO;
                  end else begin
                     pos_ff   <= pos_in;
                     state_ff <= S_TAIL;
                  end
               end
            end
            S_TAIL: begin
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (pos_ff != '0) begin
                  state_ff <= S_FOLD_GO;
               end else begin
                  mode_ff  <= MODE_FINAL;
                  tw_h_ff  <= acc_ff;
                  tw_w_ff  <= {33'h0, len_ff};
                  state_ff <= S_TW_W;
               end
            end
            S_FOLD_GO: begin
               // first lane read is under way
               mode_ff  <= MODE_FOLD;
               idx_ff   <= '0;
               tw_h_ff  <= acc_ff;
               state_ff <= S_FOLD_RD;
            end
            S_FOLD_RD: begin
               tw_w_ff  <= ram_rd_data;
               state_ff <= S_TW_W;
            end
            S_TW_W: begin
               state_ff <= S_TW_WAIT1;
            end
            S_TW_WAIT1: begin
               if (mul_done) begin
                  state_ff <= S_TW_WAIT2;
               end
            end
            S_TW_WAIT2: begin
               if (mul_done) begin
                  case (mode_ff)
                     MODE_INIT: begin
                        tw_h_ff <= mul_result;
                        if (idx_ff == LAST_IDX) begin
                           acc_ff    <= seed_ff;
                           pos_ff    <= '0;
                           in_msg_ff <= 1'b1;
                           state_ff  <= S_DATA;
                        end else begin
                           idx_ff   <= idx_in;
                           tw_w_ff  <= {{(64 - IDX_W){1'b0}}, idx_in};
                           state_ff <= S_TW_W;
                        end
                     end
                     MODE_FOLD: begin
                        acc_ff  <= mul_result;
                        tw_h_ff <= mul_result;
                        if (idx_ff == LAST_IDX) begin
                           pos_ff   <= '0;
                           state_ff <= S_TAIL;
                        end else begin
                           idx_ff   <= idx_in;
                           state_ff <= S_FOLD_RD;
                        end
                     end
                     default: begin
                        state_ff <= S_OUT;
                     end
                  endcase
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hash_ff  <= mul_result;
                  in_msg_ff    <= 1'b0;
                  pos_ff       <= '0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule
